[sv/sud_pkg.sv]
// ----------------------------------------------------------------------------
// sud_pkg
// Shared types and codes for the signed/unsigned restoring divider.
// ----------------------------------------------------------------------------
package sud_pkg;

  // Operation code carried with each request.
  localparam logic OP_SIGNED = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_N,
    ST_NEG_D,
    ST_DIV,
    ST_FIX_Q,
    ST_FIX_R
  } sud_state_e;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic neg_n;
    logic neg_d;
    logic step;
    logic fix_q;
    logic fix_r;
  } sud_ctrl_t;

endpackage

[sv/sud_if.sv]
// ----------------------------------------------------------------------------
// sud_if
// Valid/ready channels for divider requests and divider results.
// ----------------------------------------------------------------------------
interface sud_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  modport source (output valid, opcode, dividend, divisor, input ready);
  modport sink   (input valid, opcode, dividend, divisor, output ready);
endinterface

interface sud_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;
  logic                  divide_by_zero;

  modport source (output valid, quotient, remainder, divide_by_zero, input ready);
  modport sink   (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface

[sv/signed_unsigned_divider_core.sv]
// ----------------------------------------------------------------------------
// signed_unsigned_divider_core
// Signed and unsigned integer divider, radix-2 restoring, one bit a cycle.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (opcode, dividend, divisor) and results leave on
// rsp_o (quotient, remainder, divide_by_zero); both are valid/ready channels.
// A request is taken only while the divider is idle. From the request
// transfer to a valid result, the sequencer takes the magnitudes of the
// dividend and the divisor in turn, runs one shift-subtract step per
// quotient bit through the single shared subtractor, and restores the signs
// of quotient and remainder. A new request can be taken in the cycle after
// the result is loaded, as the sequencer returns to idle with that load; the
// divider works on one request at a time. The result sits in an output
// register, so the next request is accepted while the previous result waits;
// if that result is still untaken when the next one is ready, the sequencer
// holds in its last step until the receiver takes it. A zero divisor returns
// all ones, the dividend as remainder and the flag set. Reset clears the
// result valid flag and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_core #(
  parameter int DATA_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  sud_req_if.sink    req_i,
  sud_rsp_if.source  rsp_o
);

  sud_pkg::sud_ctrl_t ctrl;
  logic               out_busy;

  sud_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  sud_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .opcode_i        (req_i.opcode),
    .dividend_i      (req_i.dividend),
    .divisor_i       (req_i.divisor),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .quotient_o      (rsp_o.quotient),
    .remainder_o     (rsp_o.remainder),
    .divide_by_zero_o(rsp_o.divide_by_zero),
    .out_busy_o      (out_busy)
  );

endmodule

[sv/sud_ctrl.sv]
// ----------------------------------------------------------------------------
// sud_ctrl
// Sequencer that steps the shared subtractor through sign handling, one
// quotient bit per cycle, and the final sign fix-up.
// ----------------------------------------------------------------------------
module sud_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              out_busy_i,
  output sud_pkg::sud_ctrl_t ctrl_o
);

  localparam int CntW = $clog2(DATA_WIDTH);

  sud_pkg::sud_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sud_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and bit counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      sud_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = sud_pkg::ST_NEG_N;
        end
      end
      sud_pkg::ST_NEG_N: begin
        state_d = sud_pkg::ST_NEG_D;
      end
      sud_pkg::ST_NEG_D: begin
        state_d = sud_pkg::ST_DIV;
        cnt_d   = CntW'(DATA_WIDTH - 1);
      end
      sud_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = sud_pkg::ST_FIX_Q;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      sud_pkg::ST_FIX_Q: begin
        state_d = sud_pkg::ST_FIX_R;
      end
      sud_pkg::ST_FIX_R: begin
        // Hold here until the result register is free to take the transfer.
        if (!out_busy_i) begin
          state_d = sud_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sud_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    case (state_q)
      sud_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        ctrl_o.load = req_valid_i;
      end
      sud_pkg::ST_NEG_N: ctrl_o.neg_n = 1'b1;
      sud_pkg::ST_NEG_D: ctrl_o.neg_d = 1'b1;
      sud_pkg::ST_DIV:   ctrl_o.step  = 1'b1;
      sud_pkg::ST_FIX_Q: ctrl_o.fix_q = 1'b1;
      sud_pkg::ST_FIX_R: ctrl_o.fix_r = !out_busy_i;
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

[sv/sud_datapath.sv]
// ----------------------------------------------------------------------------
// sud_datapath
// Operand registers, the one shared subtractor and the result register.
// ----------------------------------------------------------------------------
module sud_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sud_pkg::sud_ctrl_t    ctrl_i,
  input  logic                  opcode_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic [DATA_WIDTH-1:0] quotient_o,
  output logic [DATA_WIDTH-1:0] remainder_o,
  output logic                  divide_by_zero_o,
  output logic                  out_busy_o
);

  localparam int W = DATA_WIDTH;

  // The dividend is shifted out of quo_q from the top while quotient bits
  // enter at the bottom.
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] part_q, part_d;
  logic [W-1:0] den_q, den_d;
  logic         n_neg_q, n_neg_d;
  logic         d_neg_q, d_neg_d;
  logic         dz_q, dz_d;

  logic [W-1:0] res_quo_q, res_rem_q;
  logic         res_dz_q;
  logic         rsp_valid_q;

  logic [W:0]   op_a, op_b, diff;
  logic         ge;
  logic         is_zero;

  assign is_zero = (divisor_i == '0);

  // Shared subtractor: negations are taken as zero minus the operand.
  always_comb begin
    op_a = '0;
    op_b = {1'b0, quo_q};
    if (ctrl_i.step) begin
      op_a = {part_q, quo_q[W-1]};
      op_b = {1'b0, den_q};
    end else if (ctrl_i.neg_d) begin
      op_b = {1'b0, den_q};
    end else if (ctrl_i.fix_r) begin
      op_b = {1'b0, part_q};
    end
  end

  assign diff = op_a - op_b;
  // A set top bit of the partial remainder means the shifted value already
  // exceeds any divisor, which the extra bit of the subtraction covers.
  assign ge   = ~diff[W];

  always_comb begin
    quo_d   = quo_q;
    part_d  = part_q;
    den_d   = den_q;
    n_neg_d = n_neg_q;
    d_neg_d = d_neg_q;
    dz_d    = dz_q;
    if (ctrl_i.load) begin
      quo_d   = dividend_i;
      den_d   = divisor_i;
      part_d  = '0;
      dz_d    = is_zero;
      // A zero divisor runs as unsigned, which yields all ones and the
      // dividend as remainder.
      n_neg_d = (opcode_i == sud_pkg::OP_SIGNED) && dividend_i[W-1] && !is_zero;
      d_neg_d = (opcode_i == sud_pkg::OP_SIGNED) && divisor_i[W-1];
    end
    if (ctrl_i.neg_n && n_neg_q) begin
      quo_d = diff[W-1:0];
    end
    if (ctrl_i.neg_d && d_neg_q) begin
      den_d = diff[W-1:0];
    end
    if (ctrl_i.step) begin
      part_d = ge ? diff[W-1:0] : op_a[W-1:0];
      quo_d  = {quo_q[W-2:0], ge};
    end
    if (ctrl_i.fix_q && (n_neg_q ^ d_neg_q)) begin
      quo_d = diff[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    part_q  <= part_d;
    den_q   <= den_d;
    n_neg_q <= n_neg_d;
    d_neg_q <= d_neg_d;
    dz_q    <= dz_d;
    if (ctrl_i.fix_r) begin
      res_quo_q <= quo_q;
      res_rem_q <= n_neg_q ? diff[W-1:0] : part_q;
      res_dz_q  <= dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.fix_r) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign out_busy_o       = rsp_valid_q & ~rsp_ready_i;
  assign rsp_valid_o      = rsp_valid_q;
  assign quotient_o       = res_quo_q;
  assign remainder_o      = res_rem_q;
  assign divide_by_zero_o = res_dz_q;

endmodule

[sv/sud_checker.sv]
// ----------------------------------------------------------------------------
// sud_checker
// Port-level checks on the divider, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sud_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [DATA_WIDTH-1:0] quotient_i,
  input logic [DATA_WIDTH-1:0] remainder_i,
  input logic                  divide_by_zero_i
);

  // A result that is not taken stays and keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(quotient_i)
      && $stable(remainder_i) && $stable(divide_by_zero_i))
    else $error("result changed before its transfer");

  // The divider works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // A new result appears only as the divider returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> req_ready_i)
    else $error("result raised while divider still busy");

  // Division by zero always gives an all-ones quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && divide_by_zero_i |-> (&quotient_i))
    else $error("zero divisor without all-ones quotient");

endmodule

bind signed_unsigned_divider_core sud_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sud_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .quotient_i      (rsp_o.quotient),
  .remainder_i     (rsp_o.remainder),
  .divide_by_zero_i(rsp_o.divide_by_zero)
);

[bench/signed_unsigned_divider_core_test.sv]
// ----------------------------------------------------------------------------
// signed_unsigned_divider_core_test
// Self-checking bench for the signed and unsigned restoring divider.
// ----------------------------------------------------------------------------
// Divide requests are sent in bursts with random gaps between them. Results
// are taken under a changing pattern of receiver stalls. A scoreboard works
// out the quotient, the remainder and the zero-divisor flag of every request
// that is transferred. Each result that comes back is checked in order
// against the oldest value still awaited. A directed set covers the corner
// operands of both operations, and a long random phase follows it.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_core_test;

  localparam int   DW          = 32;
  localparam int   STALL_LIMIT = 4000;
  localparam int   RANDOM_REQS = 900;
  localparam logic OP_UNSIGNED = ~sud_pkg::OP_SIGNED;

  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          divide_by_zero;
  } div_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_e;

  class divide_scoreboard;
    div_result_t awaited[$];
    int          errors     = 0;
    int          n_signed   = 0;
    int          n_unsigned = 0;
    int          n_zero     = 0;
    int          n_checked  = 0;

    // Restoring division on the magnitudes, with signs put back afterwards.
    function div_result_t compute_division(logic op, logic [DW-1:0] n, logic [DW-1:0] d);
      div_result_t   res;
      logic          n_neg, d_neg;
      logic [DW-1:0] n_mag, d_mag, quo;
      logic [DW:0]   part;
      if (d == '0) begin
        res.quotient       = '1;
        res.remainder      = n;
        res.divide_by_zero = 1'b1;
        return res;
      end
      n_neg = (op == sud_pkg::OP_SIGNED) && n[DW-1];
      d_neg = (op == sud_pkg::OP_SIGNED) && d[DW-1];
      n_mag = n_neg ? -n : n;
      d_mag = d_neg ? -d : d;
      part  = '0;
      quo   = '0;
      for (int k = DW - 1; k >= 0; k--) begin
        part = {part[DW-1:0], n_mag[k]};
        quo  = quo << 1;
        if (part >= {1'b0, d_mag}) begin
          part   = part - {1'b0, d_mag};
          quo[0] = 1'b1;
        end
      end
      res.quotient       = (n_neg != d_neg) ? -quo : quo;
      res.remainder      = n_neg ? -part[DW-1:0] : part[DW-1:0];
      res.divide_by_zero = 1'b0;
      return res;
    endfunction

    function void note_request(logic op, logic [DW-1:0] n, logic [DW-1:0] d);
      awaited.push_back(compute_division(op, n, d));
      if (op == sud_pkg::OP_SIGNED) n_signed++;
      else n_unsigned++;
      if (d == '0) n_zero++;
    endfunction

    function void check_result(div_result_t got);
      div_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited: q=%h r=%h z=%b", $time,
                 got.quotient, got.remainder, got.divide_by_zero);
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.quotient !== want.quotient) begin
        errors++;
        $display("%0t: quotient expected %h actual %h", $time, want.quotient, got.quotient);
      end
      if (got.remainder !== want.remainder) begin
        errors++;
        $display("%0t: remainder expected %h actual %h", $time, want.remainder, got.remainder);
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        errors++;
        $display("%0t: divide_by_zero expected %b actual %b", $time,
                 want.divide_by_zero, got.divide_by_zero);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sud_req_if #(.DATA_WIDTH(DW)) req_bus ();
  sud_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

  signed_unsigned_divider_core #(.DATA_WIDTH(DW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  divide_scoreboard sb = new();
  int               burst_left = 1;
  int               idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // Called at a falling edge; returns at a falling edge after the transfer
  // and after whatever gap the burst pattern asks for.
  task automatic send_request(input logic op, input logic [DW-1:0] n, input logic [DW-1:0] d);
    int gap;
    req_bus.valid    <= 1'b1;
    req_bus.opcode   <= op;
    req_bus.dividend <= n;
    req_bus.divisor  <= d;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    sb.note_request(op, n, d);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Receiver: switches between stall patterns after a span of random length.
  initial begin
    rx_mode_e mode;
    int       span;
    int       hold;
    logic     nxt;
    span = 0;
    hold = 0;
    mode = RX_OPEN;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(20, 200);
        hold = 0;
      end
      span--;
      case (mode)
        RX_OPEN:   nxt = 1'b1;
        RX_COIN:   nxt = 1'($urandom_range(0, 1));
        RX_SPARSE: nxt = ($urandom_range(0, 7) == 0);
        default: begin
          if (hold == 0) begin
            nxt  = 1'b1;
            hold = $urandom_range(10, 90);
          end else begin
            nxt = 1'b0;
            hold--;
          end
        end
      endcase
      rsp_bus.ready <= nxt;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_result({rsp_bus.quotient, rsp_bus.remainder, rsp_bus.divide_by_zero});
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still awaited", $time,
                 STALL_LIMIT, sb.pending());
        $display("signed_unsigned_divider_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic          op;
    logic [DW-1:0] n, d;
    rst_ni           <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.opcode   <= OP_UNSIGNED;
    req_bus.dividend <= '0;
    req_bus.divisor  <= '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corner operands for both operations, zero divisors among them.
    send_request(OP_UNSIGNED,        32'h0000_0000, 32'h0000_0000);
    send_request(sud_pkg::OP_SIGNED, 32'h0000_0005, 32'h0000_0000);
    send_request(OP_UNSIGNED,        32'hFFFF_FFFF, 32'h0000_0000);
    send_request(sud_pkg::OP_SIGNED, 32'h8000_0000, 32'h0000_0000);
    send_request(sud_pkg::OP_SIGNED, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_UNSIGNED,        32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_UNSIGNED,        32'hFFFF_FFFF, 32'h0000_0001);
    send_request(sud_pkg::OP_SIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(OP_UNSIGNED,        32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(sud_pkg::OP_SIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_UNSIGNED,        32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_UNSIGNED,        32'h0000_0001, 32'hFFFF_FFFF);
    send_request(sud_pkg::OP_SIGNED, 32'h0000_0007, 32'h0000_0002);
    send_request(sud_pkg::OP_SIGNED, 32'hFFFF_FFF9, 32'h0000_0002);
    send_request(sud_pkg::OP_SIGNED, 32'h0000_0007, 32'hFFFF_FFFE);
    send_request(sud_pkg::OP_SIGNED, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
    send_request(OP_UNSIGNED,        32'hFFFF_FFF9, 32'h0000_0002);
    send_request(sud_pkg::OP_SIGNED, 32'h8000_0000, 32'h0000_0001);
    send_request(sud_pkg::OP_SIGNED, 32'h8000_0000, 32'h8000_0000);
    send_request(sud_pkg::OP_SIGNED, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_UNSIGNED,        32'h7FFF_FFFF, 32'h8000_0000);
    send_request(sud_pkg::OP_SIGNED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      op = $urandom_range(0, 1) ? sud_pkg::OP_SIGNED : OP_UNSIGNED;
      n  = $urandom();
      d  = $urandom();
      case ($urandom_range(0, 15))
        0: d = '0;
        1: begin
          n = 32'h8000_0000;
          d = '1;
        end
        2, 3: begin
          d = $urandom_range(1, 15);
          if ($urandom_range(0, 1)) d = -d;
        end
        4: n = $urandom_range(0, 1000);
        5: begin
          d = $urandom() >> $urandom_range(4, 31);
          n = d * $urandom_range(0, 9);
        end
        6: d = $urandom() >> $urandom_range(0, 31);
        default: ;
      endcase
      send_request(op, n, d);
    end
    req_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DW + 8) @(posedge clk_i);

    $display("Covered %0d requests: %0d signed, %0d unsigned, %0d with a zero divisor.",
             sb.n_signed + sb.n_unsigned, sb.n_signed, sb.n_unsigned, sb.n_zero);
    $display("Checked %0d results, %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signed_unsigned_divider_core verification clean");
    end else begin
      $display("signed_unsigned_divider_core verification failed");
    end
    $finish;
  end

endmodule
